@@ rtl/ils_pkg.sv @@
`default_nettype none
package ils_pkg;

  localparam int DATA_W       = 32;
  localparam int REQ_W        = 3;
  localparam int STAT_W       = 2;
  localparam int LEN_W        = 5;
  localparam int CAPACITY_DEF = 16;
  localparam int QDEPTH_DEF   = 2;

  localparam logic [REQ_W-1:0] REQ_READ = 3'd0;
  localparam logic [REQ_W-1:0] REQ_HEAD = 3'd1;
  localparam logic [REQ_W-1:0] REQ_TAIL = 3'd2;
  localparam logic [REQ_W-1:0] REQ_AT   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_DEL  = 3'd4;

  localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STAT_W-1:0] ST_INVALID = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;

  typedef enum logic [2:0] {
    OP_READ,
    OP_HEAD,
    OP_TAIL,
    OP_AT,
    OP_DEL,
    OP_BAD
  } op_t;

  typedef struct packed {
    op_t               op;
    logic              neg;
    logic              big;
    logic [DATA_W-1:0] value;
  } cmd_t;

endpackage
`default_nettype wire

@@ rtl/indexed_list_store.sv @@
`default_nettype none
// Channel  Direction  Handshake           Payload
// in_      input      in_valid/in_stall   in_req_type, in_position, in_new_value
// out_     output     out_valid/out_stall out_read_value, out_status, out_length
//
// One transaction is taken and completed per cycle when neither side stalls.
// A request waits in the command queue, and its result is registered in the
// output register as it is popped; the cell row shifts all entries on that pop.
// Reset clears the list length, the queue and the output valid flag.
// The input stalls only while the command queue is full.
module indexed_list_store #(
  parameter int CAPACITY = ils_pkg::CAPACITY_DEF,
  parameter int QDEPTH   = ils_pkg::QDEPTH_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [ils_pkg::REQ_W-1:0]          in_req_type,
  input  wire logic signed [ils_pkg::DATA_W-1:0]  in_position,
  input  wire logic signed [ils_pkg::DATA_W-1:0]  in_new_value,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic signed [ils_pkg::DATA_W-1:0]       out_read_value,
  output logic [ils_pkg::STAT_W-1:0]              out_status,
  output logic [ils_pkg::LEN_W-1:0]               out_length
);
  import ils_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int QW = $bits(cmd_t) + CW;

  cmd_t          f_cmd;
  logic [CW-1:0] f_idx;
  logic          push;
  logic          q_full;
  logic          q_empty;
  logic          pop;
  logic [QW-1:0] q_data;
  cmd_t          q_cmd;
  logic [CW-1:0] q_idx;

  ils_front #(
    .CAPACITY (CAPACITY),
    .CW       (CW)
  ) u_front (
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_req_type  (in_req_type),
    .in_position  (in_position),
    .in_new_value (in_new_value),
    .q_full       (q_full),
    .push         (push),
    .cmd          (f_cmd),
    .idx          (f_idx)
  );

  ils_queue #(
    .W     (QW),
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data ({f_cmd, f_idx}),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (q_data),
    .empty     (q_empty)
  );

  assign {q_cmd, q_idx} = q_data;

  ils_back #(
    .CAPACITY (CAPACITY),
    .CW       (CW)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_cmd          (q_cmd),
    .q_idx          (q_idx),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_read_value (out_read_value),
    .out_status     (out_status),
    .out_length     (out_length)
  );

endmodule
`default_nettype wire

@@ rtl/ils_front.sv @@
`default_nettype none
module ils_front #(
  parameter int CAPACITY = ils_pkg::CAPACITY_DEF,
  parameter int CW       = $clog2(CAPACITY + 1)
) (
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [ils_pkg::REQ_W-1:0]          in_req_type,
  input  wire logic signed [ils_pkg::DATA_W-1:0]  in_position,
  input  wire logic signed [ils_pkg::DATA_W-1:0]  in_new_value,
  input  wire logic                               q_full,
  output logic                                    push,
  output ils_pkg::cmd_t                           cmd,
  output logic [CW-1:0]                           idx
);
  import ils_pkg::*;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    cmd.neg   = in_position[DATA_W-1];
    cmd.big   = !in_position[DATA_W-1] &&
                (unsigned'(in_position) > DATA_W'(CAPACITY));
    cmd.value = in_new_value;
    case (in_req_type)
      REQ_READ: cmd.op = OP_READ;
      REQ_HEAD: cmd.op = OP_HEAD;
      REQ_TAIL: cmd.op = OP_TAIL;
      REQ_AT:   cmd.op = OP_AT;
      REQ_DEL:  cmd.op = OP_DEL;
      default:  cmd.op = OP_BAD;
    endcase
  end

  assign idx = in_position[CW-1:0];

endmodule
`default_nettype wire

@@ rtl/ils_queue.sv @@
`default_nettype none
module ils_queue #(
  parameter int W     = 8,
  parameter int DEPTH = ils_pkg::QDEPTH_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire logic [W-1:0] push_data,
  output logic              full,
  input  wire logic         pop,
  output logic [W-1:0]      pop_data,
  output logic              empty
);
  import ils_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [NW-1:0] fill_r, fill_nxt;

  assign full     = (fill_r == NW'(DEPTH));
  assign empty    = (fill_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (pop && !push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= NW'(DEPTH))
    else $error("queue occupancy beyond its depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full && !pop |-> !push)
    else $error("push into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    empty |-> !pop)
    else $error("pop from an empty queue");

endmodule
`default_nettype wire

@@ rtl/ils_back.sv @@
`default_nettype none
module ils_back #(
  parameter int CAPACITY = ils_pkg::CAPACITY_DEF,
  parameter int CW       = $clog2(CAPACITY + 1)
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         q_empty,
  input  wire ils_pkg::cmd_t                q_cmd,
  input  wire logic [CW-1:0]                q_idx,
  output logic                              pop,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [ils_pkg::DATA_W-1:0]        out_read_value,
  output logic [ils_pkg::STAT_W-1:0]        out_status,
  output logic [ils_pkg::LEN_W-1:0]         out_length
);
  import ils_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic [DATA_W-1:0] cells_r [CAPACITY];
  logic [CW-1:0]     count_r, count_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_read_value_r, out_read_value_nxt;
  logic [STAT_W-1:0] out_status_r, out_status_nxt;
  logic [LEN_W-1:0]  out_length_r, out_length_nxt;

  logic          in_list;
  logic          list_full;
  logic          do_ins;
  logic          do_del;
  logic          shift_ins;
  logic          shift_del;
  logic [CW-1:0] ins_slot;

  assign pop       = !q_empty && (!out_valid_r || !out_stall);
  assign in_list   = !q_cmd.neg && !q_cmd.big && (q_idx < count_r);
  assign list_full = (count_r == CW'(CAPACITY));
  assign shift_ins = pop && do_ins;
  assign shift_del = pop && do_del;

  always_comb begin
    logic ins_req;
    ins_req            = 1'b0;
    do_ins             = 1'b0;
    do_del             = 1'b0;
    ins_slot           = '0;
    out_read_value_nxt = '0;
    out_status_nxt     = ST_DONE;
    case (q_cmd.op)
      OP_READ: begin
        if (in_list) begin
          out_read_value_nxt = cells_r[q_idx[AW-1:0]];
        end else begin
          out_read_value_nxt = '1;
          out_status_nxt     = ST_INVALID;
        end
      end
      OP_HEAD: begin
        ins_req = 1'b1;
      end
      OP_TAIL: begin
        ins_req  = 1'b1;
        ins_slot = count_r;
      end
      OP_AT: begin
        if (!q_cmd.neg && (q_cmd.big || (q_idx > count_r))) begin
          out_status_nxt = ST_INVALID;
        end else begin
          ins_req  = 1'b1;
          ins_slot = q_cmd.neg ? '0 : q_idx;
        end
      end
      OP_DEL: begin
        if (in_list) begin
          do_del = 1'b1;
        end else begin
          out_status_nxt = ST_INVALID;
        end
      end
      default: begin
        out_status_nxt = ST_INVALID;
      end
    endcase
    if (ins_req) begin
      if (list_full) begin
        out_status_nxt = ST_FULL;
      end else begin
        do_ins = 1'b1;
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (shift_ins) begin
      count_nxt = count_r + 1'b1;
    end else if (shift_del) begin
      count_nxt = count_r - 1'b1;
    end
    out_length_nxt = LEN_W'(count_nxt);
  end

  always_comb begin
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] cell_nxt;
    logic [DATA_W-1:0] lower;
    logic [DATA_W-1:0] upper;

    if (i > 0) begin : g_lower
      assign lower = cells_r[i-1];
    end else begin : g_first
      assign lower = cells_r[i];
    end

    if (i < CAPACITY - 1) begin : g_upper
      assign upper = cells_r[i+1];
    end else begin : g_last
      assign upper = cells_r[i];
    end

    always_comb begin
      cell_nxt = cells_r[i];
      if (shift_ins && (CW'(i) == ins_slot)) begin
        cell_nxt = q_cmd.value;
      end else if (shift_ins && (CW'(i) > ins_slot)) begin
        cell_nxt = lower;
      end else if (shift_del && (CW'(i) >= q_idx)) begin
        cell_nxt = upper;
      end
    end

    always_ff @(posedge clk) begin
      cells_r[i] <= cell_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_read_value_r <= out_read_value_nxt;
      out_status_r     <= out_status_nxt;
      out_length_r     <= out_length_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_value = out_read_value_r;
  assign out_status     = out_status_r;
  assign out_length     = out_length_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("list length beyond capacity");

  a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !pop |=> $stable(count_r))
    else $error("list length changed without a transaction");

  a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r == ST_FULL) |-> (out_length_r == LEN_W'(CAPACITY)))
    else $error("full status reported below capacity");

endmodule
`default_nettype wire

@@ verif/testbench.sv @@
`default_nettype none
module testbench;
  import ils_pkg::*;

  localparam int CAPACITY = CAPACITY_DEF;
  localparam int HOLD_CYCLES = 300;
  localparam logic [REQ_W-1:0] REQ_UNUSED_LO = 3'd5;

  typedef struct {
    logic [DATA_W-1:0] read_value;
    logic [STAT_W-1:0] status;
    logic [LEN_W-1:0]  length;
  } reply_t;

  // Shadow copy of the list, updated as each request is accepted, with the
  // replies it implies waiting in order of arrival.
  class list_shadow;
    logic [DATA_W-1:0] cells [CAPACITY];
    int fill;
    int mismatches;
    reply_t awaited[$];

    function new();
      fill = 0;
      mismatches = 0;
    endfunction

    function void note_request(logic [REQ_W-1:0] kind, logic [DATA_W-1:0] pos,
                               logic [DATA_W-1:0] value);
      reply_t r;
      int p;
      int slot;
      int i;
      bit in_range;
      bit ok;
      p = int'(signed'(pos));
      r.read_value = '0;
      r.status = ST_DONE;
      in_range = (p >= 0) && (p < fill);
      case (kind)
        REQ_READ: begin
          if (in_range) begin
            r.read_value = cells[p];
          end else begin
            r.read_value = '1;
            r.status = ST_INVALID;
          end
        end
        REQ_HEAD, REQ_TAIL, REQ_AT: begin
          slot = 0;
          ok = 1'b1;
          if (kind == REQ_TAIL) begin
            slot = fill;
          end else if (kind == REQ_AT) begin
            if (p > fill) ok = 1'b0;
            else if (p > 0) slot = p;
          end
          if (!ok) begin
            r.status = ST_INVALID;
          end else if (fill >= CAPACITY) begin
            r.status = ST_FULL;
          end else begin
            for (i = fill; i > slot; i--) cells[i] = cells[i - 1];
            cells[slot] = value;
            fill++;
          end
        end
        REQ_DEL: begin
          if (in_range) begin
            for (i = p; i + 1 < fill; i++) cells[i] = cells[i + 1];
            fill--;
          end else begin
            r.status = ST_INVALID;
          end
        end
        default: begin
          r.status = ST_INVALID;
        end
      endcase
      r.length = LEN_W'(fill);
      awaited.push_back(r);
    endfunction

    task flag_mismatch(string what);
      $display("mismatch: %s", what);
      mismatches++;
    endtask

    task check_reply(logic [DATA_W-1:0] got_value, logic [STAT_W-1:0] got_status,
                     logic [LEN_W-1:0] got_length);
      reply_t want;
      if (awaited.size() == 0) begin
        flag_mismatch($sformatf("unexpected result: value %h status %0d length %0d",
                                got_value, got_status, got_length));
      end else begin
        want = awaited.pop_front();
        if (got_value !== want.read_value)
          flag_mismatch($sformatf("read_value %h, expected %h", got_value, want.read_value));
        if (got_status !== want.status)
          flag_mismatch($sformatf("status %0d, expected %0d", got_status, want.status));
        if (got_length !== want.length)
          flag_mismatch($sformatf("length %0d, expected %0d", got_length, want.length));
      end
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [REQ_W-1:0] in_req_type;
  logic signed [DATA_W-1:0] in_position;
  logic signed [DATA_W-1:0] in_new_value;
  logic out_valid;
  logic out_stall;
  logic signed [DATA_W-1:0] out_read_value;
  logic [STAT_W-1:0] out_status;
  logic [LEN_W-1:0] out_length;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_off_req = 1'b0;
  list_shadow tracker = new();

  indexed_list_store DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_req_type    (in_req_type),
    .in_position    (in_position),
    .in_new_value   (in_new_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_read_value (out_read_value),
    .out_status     (out_status),
    .out_length     (out_length)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #(4 * 100000);
    $display("TEST FAILED");
    $finish;
  end

  // The receiver stalls at random, and on request holds off for a long stretch
  // so that the block fills up and stalls its input.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      tracker.check_reply(out_read_value, out_status, out_length);
  end

  // Entered and left at a falling edge.
  task automatic send_request(input logic [REQ_W-1:0] kind, input logic [DATA_W-1:0] pos,
                              input logic [DATA_W-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= kind;
    in_position <= pos;
    in_new_value <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.note_request(kind, pos, value);
    @(negedge clk);
  endtask

  task automatic send_random(input int insert_bias);
    int roll;
    int spot;
    logic [REQ_W-1:0] kind;
    logic [DATA_W-1:0] value;
    roll = $urandom_range(99);
    if (roll < 3) kind = REQ_UNUSED_LO + REQ_W'($urandom_range(2));
    else if (roll < 3 + insert_bias) kind = REQ_HEAD + REQ_W'($urandom_range(2));
    else if (roll % 2 == 1) kind = REQ_READ;
    else kind = REQ_DEL;
    roll = $urandom_range(99);
    if (roll < 70) spot = $urandom_range(tracker.fill);
    else if (roll < 80) spot = tracker.fill + 1;
    else if (roll < 88) spot = -int'($urandom_range(4, 1));
    else spot = $urandom;
    roll = $urandom_range(99);
    if (roll < 3) value = 32'h8000_0000;
    else if (roll < 6) value = 32'h7fff_ffff;
    else if (roll < 8) value = '0;
    else if (roll < 10) value = '1;
    else value = $urandom;
    send_request(kind, spot, value);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (tracker.awaited.size() != 0) @(negedge clk);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req_type = REQ_READ;
    in_position = '0;
    in_new_value = '0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 9;
    recv_idle_pct = 55;
    send_request(REQ_READ, 32'd0, 32'd0);
    send_request(REQ_READ, 32'h8000_0000, 32'd0);
    send_request(REQ_DEL, 32'd0, 32'd0);
    send_request(REQ_AT, 32'd1, 32'd9);
    send_request(REQ_AT, 32'hffff_ffff, 32'h7fff_ffff);
    send_request(REQ_AT, 32'd1, 32'h8000_0000);
    send_request(REQ_HEAD, 32'h7fff_ffff, 32'd0);
    send_request(REQ_TAIL, 32'h8000_0000, 32'hffff_ffff);
    send_request(REQ_AT, 32'd2, 32'h1234_5678);
    send_request(REQ_READ, 32'd0, 32'd0);
    send_request(REQ_READ, 32'd4, 32'd0);
    send_request(REQ_READ, 32'd5, 32'd0);
    send_request(REQ_READ, 32'h7fff_ffff, 32'd0);
    send_request(REQ_UNUSED_LO, 32'd0, 32'h5555_5555);
    send_request(REQ_UNUSED_LO + 3'd1, 32'd1, 32'haaaa_aaaa);
    send_request(REQ_UNUSED_LO + 3'd2, 32'd2, 32'd1);
    send_request(REQ_DEL, 32'hffff_ffff, 32'd0);
    send_request(REQ_DEL, 32'd4, 32'd0);
    send_request(REQ_DEL, 32'd0, 32'd0);
    send_request(REQ_READ, 32'hffff_ffff, 32'd0);

    for (int n = 0; n < 220; n++) begin
      if (n == 110) wait_drained();
      send_random(((n / 40) % 2 == 0) ? 75 : 20);
    end

    send_idle_pct = 55;
    recv_idle_pct = 9;
    hold_off_req = 1'b1;
    for (int n = 0; n < 240; n++) send_random(((n / 40) % 2 == 0) ? 70 : 25);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int n = 0; n < 200; n++) send_random(((n / 30) % 2 == 0) ? 80 : 20);

    wait_drained();
    repeat (8) @(negedge clk);
    if (tracker.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire

@@ sim.f @@
rtl/ils_pkg.sv
rtl/ils_front.sv
rtl/ils_queue.sv
rtl/ils_back.sv
rtl/indexed_list_store.sv
verif/testbench.sv
